// ===== hw/rtl/dpdc_pkg.sv =====
// Package for the Gregorian date period day counter.
// Holds field widths, the calendar constants, the sequencer state type and the
// control word that the top level sends to the date stepper. It has no dependencies.
package dpdc_pkg;

  localparam int unsigned DayW   = 5;
  localparam int unsigned MonthW = 4;
  localparam int unsigned YearW  = 14;
  localparam int unsigned CountW = 22;

  localparam logic [YearW-1:0] YearMax = 14'd9999;
  localparam logic [MonthW-1:0] MonthLast = 4'd12;

  // The year is divided by 100 as a multiply by 5243 followed by a right shift of 19.
  // This gives the exact quotient for every 14-bit year.
  localparam int unsigned RecipW     = 13;
  localparam logic [RecipW-1:0] Recip100 = 13'd5243;
  localparam int unsigned ProdW      = YearW + RecipW;
  localparam int unsigned RecipShift = 19;
  localparam int unsigned CentW      = ProdW - RecipShift;
  localparam int unsigned Mod100W    = 7;
  localparam logic [Mod100W-1:0] Mod100Last = 7'd99;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MUL_S = 7'b0000010,
    S_CHK_S = 7'b0000100,
    S_MUL_E = 7'b0001000,
    S_CHK_E = 7'b0010000,
    S_STEP  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  typedef struct packed {
    logic load;
    logic advance;
  } step_ctrl_t;

  // Length of a month. A month code outside January to December returns zero.
  function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] month,
                                                 input logic leap);
    logic [DayW-1:0] len;
    unique case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

// ===== hw/rtl/dpdc_step.sv =====
// Date stepper for the day counter: holds the running date and advances it by one day.
// It keeps the year modulo 100 and the century modulo 4 as counters for the leap-year rule.
// It depends on dpdc_pkg.
module dpdc_step (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  dpdc_pkg::step_ctrl_t             ctrl_i,
  input  logic [dpdc_pkg::DayW-1:0]        day_i,
  input  logic [dpdc_pkg::MonthW-1:0]      month_i,
  input  logic [dpdc_pkg::YearW-1:0]       year_i,
  input  logic [dpdc_pkg::Mod100W-1:0]     mod100_i,
  input  logic [1:0]                       cent_mod4_i,
  output logic [dpdc_pkg::DayW-1:0]        day_o,
  output logic [dpdc_pkg::MonthW-1:0]      month_o,
  output logic [dpdc_pkg::YearW-1:0]       year_o
);

  logic [dpdc_pkg::DayW-1:0]    day_q, day_d;
  logic [dpdc_pkg::MonthW-1:0]  month_q, month_d;
  logic [dpdc_pkg::YearW-1:0]   year_q, year_d;
  logic [dpdc_pkg::Mod100W-1:0] mod100_q, mod100_d;
  logic [1:0]                   cent_mod4_q, cent_mod4_d;
  logic                         leap;
  logic [dpdc_pkg::DayW-1:0]    len;

  // The low two bits of the year are the year modulo 4.
  assign leap = (mod100_q == '0) ? (cent_mod4_q == 2'd0) : (year_q[1:0] == 2'd0);
  assign len  = dpdc_pkg::month_days(month_q, leap);

  always_comb begin
    day_d       = day_q;
    month_d     = month_q;
    year_d      = year_q;
    mod100_d    = mod100_q;
    cent_mod4_d = cent_mod4_q;
    if (ctrl_i.load) begin
      day_d       = day_i;
      month_d     = month_i;
      year_d      = year_i;
      mod100_d    = mod100_i;
      cent_mod4_d = cent_mod4_i;
    end else if (ctrl_i.advance) begin
      if (day_q == len) begin
        day_d = 5'd1;
        if (month_q == dpdc_pkg::MonthLast) begin
          month_d = 4'd1;
          year_d  = year_q + 14'd1;
          if (mod100_q == dpdc_pkg::Mod100Last) begin
            mod100_d    = '0;
            cent_mod4_d = cent_mod4_q + 2'd1;
          end else begin
            mod100_d = mod100_q + 7'd1;
          end
        end else begin
          month_d = month_q + 4'd1;
        end
      end else begin
        day_d = day_q + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      day_q       <= '0;
      month_q     <= '0;
      year_q      <= '0;
      mod100_q    <= '0;
      cent_mod4_q <= '0;
    end else begin
      day_q       <= day_d;
      month_q     <= month_d;
      year_q      <= year_d;
      mod100_q    <= mod100_d;
      cent_mod4_q <= cent_mod4_d;
    end
  end

  assign day_o   = day_q;
  assign month_o = month_q;
  assign year_o  = year_q;

endmodule

// ===== hw/rtl/date_period_day_count.sv =====
// Gregorian date period day counter, top level.
// It holds the sequencer, the shared year divider and the output word register.
// It depends on dpdc_pkg and dpdc_step.
//
// Usage:
// The input channel carries a start date, an end date and an include-end flag,
// and a word is taken when in_valid_i is high and in_stall_o is low. The output
// channel returns the day count and a bad-date flag, and hands over a word when
// out_valid_o is high and out_stall_i is low.
// Both dates are checked in turn, multiply then check for each, as the two year
// checks share one multiplier that divides the year by 100. The day loop then
// takes one cycle for each day from the start to the end, then tests for the end,
// and the output register is loaded once it is free. An invalid date skips the
// loop. The next word can be taken in the cycle after the result is loaded.
// in_stall_o is high from acceptance until the result is in the output register.
// A result waits there while out_stall_i is high; a new word can be taken
// meanwhile, but its result is held back until the first one is taken.
// Reset clears the sequencer and the output valid flag; the block is then ready.
module date_period_day_count (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [dpdc_pkg::DayW-1:0]           start_day_i,
  input  logic [dpdc_pkg::MonthW-1:0]         start_month_i,
  input  logic [dpdc_pkg::YearW-1:0]          start_year_i,
  input  logic [dpdc_pkg::DayW-1:0]           end_day_i,
  input  logic [dpdc_pkg::MonthW-1:0]         end_month_i,
  input  logic [dpdc_pkg::YearW-1:0]          end_year_i,
  input  logic                                include_end_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [dpdc_pkg::CountW-1:0]         day_count_o,
  output logic                                bad_date_o
);

  dpdc_pkg::state_e state_q, state_d;

  logic [dpdc_pkg::DayW-1:0]   sd_q, ed_q;
  logic [dpdc_pkg::MonthW-1:0] sm_q, em_q;
  logic [dpdc_pkg::YearW-1:0]  sy_q, ey_q;
  logic                        inc_q;
  logic                        start_ok_q, start_ok_d;
  logic [dpdc_pkg::CountW-1:0] count_q, count_d;
  logic                        bad_q, bad_d;
  logic [dpdc_pkg::ProdW-1:0]  prod_q;
  logic                        out_valid_q, out_valid_d;
  logic [dpdc_pkg::CountW-1:0] out_count_q;
  logic                        out_bad_q;

  logic                         accept;
  logic                         out_free;
  logic [dpdc_pkg::YearW-1:0]   sel_year;
  logic [dpdc_pkg::DayW-1:0]    sel_day;
  logic [dpdc_pkg::MonthW-1:0]  sel_month;
  logic [dpdc_pkg::CentW-1:0]   cent;
  logic [dpdc_pkg::YearW-1:0]   rem_wide;
  logic [dpdc_pkg::Mod100W-1:0] rem;
  logic                         leap;
  logic                         date_ok;
  logic                         before_end;

  dpdc_pkg::step_ctrl_t         step_ctrl;
  logic [dpdc_pkg::DayW-1:0]    cur_day;
  logic [dpdc_pkg::MonthW-1:0]  cur_month;
  logic [dpdc_pkg::YearW-1:0]   cur_year;

  assign in_stall_o = (state_q != dpdc_pkg::S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // The year unit serves the start date first and then the end date.
  assign sel_year  = (state_q == dpdc_pkg::S_MUL_E || state_q == dpdc_pkg::S_CHK_E) ? ey_q : sy_q;
  assign sel_day   = (state_q == dpdc_pkg::S_CHK_E) ? ed_q : sd_q;
  assign sel_month = (state_q == dpdc_pkg::S_CHK_E) ? em_q : sm_q;

  assign cent     = prod_q[dpdc_pkg::ProdW-1:dpdc_pkg::RecipShift];
  assign rem_wide = sel_year - (14'(cent) * 14'd100);
  assign rem      = rem_wide[dpdc_pkg::Mod100W-1:0];
  // A year divisible by 400 is a whole century whose century count is a multiple of 4.
  assign leap     = (rem == '0) ? (cent[1:0] == 2'd0) : (sel_year[1:0] == 2'd0);
  assign date_ok  = (sel_year != '0) && (sel_year <= dpdc_pkg::YearMax) && (sel_day != '0)
                    && (sel_day <= dpdc_pkg::month_days(sel_month, leap));

  assign before_end = {cur_year, cur_month, cur_day} < {ey_q, em_q, ed_q};

  always_comb begin
    state_d        = state_q;
    start_ok_d     = start_ok_q;
    count_d        = count_q;
    bad_d          = bad_q;
    out_valid_d    = out_valid_q && out_stall_i;
    step_ctrl      = '0;
    unique case (state_q)
      dpdc_pkg::S_IDLE: begin
        if (accept) begin
          state_d = dpdc_pkg::S_MUL_S;
        end
      end
      dpdc_pkg::S_MUL_S: state_d = dpdc_pkg::S_CHK_S;
      dpdc_pkg::S_CHK_S: begin
        start_ok_d     = date_ok;
        step_ctrl.load = 1'b1;
        state_d        = dpdc_pkg::S_MUL_E;
      end
      dpdc_pkg::S_MUL_E: state_d = dpdc_pkg::S_CHK_E;
      dpdc_pkg::S_CHK_E: begin
        count_d = '0;
        if (start_ok_q && date_ok) begin
          bad_d   = 1'b0;
          state_d = dpdc_pkg::S_STEP;
        end else begin
          bad_d   = 1'b1;
          state_d = dpdc_pkg::S_DONE;
        end
      end
      dpdc_pkg::S_STEP: begin
        if (before_end) begin
          step_ctrl.advance = 1'b1;
          count_d           = count_q + 22'd1;
        end else begin
          count_d = count_q + 22'(inc_q);
          state_d = dpdc_pkg::S_DONE;
        end
      end
      dpdc_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = dpdc_pkg::S_IDLE;
        end
      end
      default: state_d = dpdc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dpdc_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sd_q  <= start_day_i;
      sm_q  <= start_month_i;
      sy_q  <= start_year_i;
      ed_q  <= end_day_i;
      em_q  <= end_month_i;
      ey_q  <= end_year_i;
      inc_q <= include_end_i;
    end
    prod_q     <= dpdc_pkg::ProdW'(sel_year) * dpdc_pkg::ProdW'(dpdc_pkg::Recip100);
    start_ok_q <= start_ok_d;
    count_q    <= count_d;
    bad_q      <= bad_d;
    if (state_q == dpdc_pkg::S_DONE && out_free) begin
      out_count_q <= count_q;
      out_bad_q   <= bad_q;
    end
  end

  dpdc_step u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (step_ctrl),
    .day_i       (sd_q),
    .month_i     (sm_q),
    .year_i      (sy_q),
    .mod100_i    (rem),
    .cent_mod4_i (cent[1:0]),
    .day_o       (cur_day),
    .month_o     (cur_month),
    .year_o      (cur_year)
  );

  assign out_valid_o = out_valid_q;
  assign day_count_o = out_count_q;
  assign bad_date_o  = out_bad_q;

endmodule
